/* src/prq_pkg.sv */
// shared types, widths and codes of the packet ring queue
package prq_pkg;

  localparam int MAX_SLOTS_DEF = 16;
  localparam int MAX_BYTES_DEF = 64;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 7;
  localparam int FILL_W    = 5;
  localparam int STAT_W    = 16;
  localparam int LIMIT_W   = 10;
  localparam int STATUS_W  = 3;
  localparam int SLOTS_W   = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STORE_LEN = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NONE      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd4;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b1;

  localparam logic [SLOTS_W-1:0] SLOTS_RST  = 5'd16;
  localparam logic [STAT_W-1:0]  PERIOD_RST = 16'd1000;

  typedef struct packed {
    logic [SLOTS_W-1:0] slots;
    logic [STAT_W-1:0]  period;
  } cfg_t;

  typedef struct packed {
    logic                operation;
    logic [BYTE_W-1:0]   data;
    logic                last;
    logic [LIMIT_W-1:0]  limit;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   data;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    len;
    logic [FILL_W-1:0]   fill;
    logic [STAT_W-1:0]   peak;
  } res_t;

endpackage

/* src/prq_ram.sv */
// simple dual-port byte memory with registered read
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/prq_ctrl.sv */
// sequencer of the packet ring queue: assembly, copy, slot scan and read-out
module prq_ctrl #(
  parameter int MAX_SLOTS = 16,
  parameter int MAX_BYTES = 64
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  prq_pkg::cfg_t                            cfg,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  prq_pkg::item_t                           item,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output prq_pkg::res_t                            res,
  output logic                                     asm_we,
  output logic [$clog2(MAX_BYTES)-1:0]             asm_waddr,
  output logic [prq_pkg::BYTE_W-1:0]               asm_wdata,
  output logic [$clog2(MAX_BYTES)-1:0]             asm_raddr,
  input  logic [prq_pkg::BYTE_W-1:0]               asm_rdata,
  output logic                                     slot_we,
  output logic [$clog2(MAX_SLOTS*MAX_BYTES)-1:0]   slot_waddr,
  output logic [prq_pkg::BYTE_W-1:0]               slot_wdata,
  output logic [$clog2(MAX_SLOTS*MAX_BYTES)-1:0]   slot_raddr,
  input  logic [prq_pkg::BYTE_W-1:0]               slot_rdata
);
  import prq_pkg::*;

  localparam int SW = $clog2(MAX_SLOTS);
  localparam int NW = $clog2(MAX_SLOTS + 1);
  localparam int AW = $clog2(MAX_BYTES);
  localparam int LW = $clog2(MAX_BYTES + 1);
  localparam int MW = $clog2(MAX_SLOTS * MAX_BYTES);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_COPY    = 4'd1;
  localparam logic [3:0] S_RES     = 4'd2;
  localparam logic [3:0] S_SCAN    = 4'd3;
  localparam logic [3:0] S_CHECK   = 4'd4;
  localparam logic [3:0] S_CMP     = 4'd5;
  localparam logic [3:0] S_EMIT_RD = 4'd6;
  localparam logic [3:0] S_EMIT    = 4'd7;

  logic [3:0]          state;
  logic [SW-1:0]       store_index;
  logic [SW-1:0]       read_index;
  logic [FILL_W-1:0]   filled;
  logic [STAT_W-1:0]   outstanding;
  logic [STAT_W-1:0]   peak;
  logic [STAT_W-1:0]   period_cnt;
  logic [LW-1:0]       asm_cnt;
  logic                asm_ovf;
  logic [MAX_SLOTS-1:0] queued;
  logic [LW-1:0]       slot_len [MAX_SLOTS];
  logic [SW-1:0]       cand;
  logic [NW-1:0]       remaining;
  logic [LIMIT_W-1:0]  limit;
  logic [LW-1:0]       len;
  logic [MW-1:0]       base;
  logic [LW-1:0]       cj;
  logic [LW-1:0]       wj;
  logic                wv;
  logic [LW-1:0]       ej;
  logic [STATUS_W-1:0] pend_status;
  logic [LW-1:0]       pend_len;

  logic [NW-1:0]       n;
  logic                accept;
  logic                out_free;
  logic                out_load;
  logic                asm_full;
  logic [LW-1:0]       asm_len;
  logic [STAT_W-1:0]   out_inc;
  logic [STAT_W-1:0]   period_inc;
  logic                emit_last;

  function automatic logic [SW-1:0] wrap(input logic [SW-1:0] idx, input logic [NW-1:0] cnt);
    logic [SW:0] nxt;
    nxt = {1'b0, idx} + (SW+1)'(1);
    if (32'(nxt) >= 32'(cnt)) begin
      return '0;
    end
    return nxt[SW-1:0];
  endfunction

  always_comb begin
    if (cfg.slots == '0) begin
      n = NW'(1);
    end else if (32'(cfg.slots) > MAX_SLOTS) begin
      n = NW'(MAX_SLOTS);
    end else begin
      n = NW'(cfg.slots);
    end
  end

  assign in_stall   = rst || (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign out_load   = out_free && ((state == S_RES) || (state == S_EMIT));
  assign asm_full   = (asm_cnt == LW'(MAX_BYTES));
  assign asm_len    = LW'(asm_cnt + 1'b1);
  assign out_inc    = (outstanding != '1) ? outstanding + 1'b1 : outstanding;
  assign period_inc = period_cnt + 1'b1;
  assign emit_last  = (LW'(ej + 1'b1) == len);

  assign asm_we    = accept && (item.operation == OP_STORE) && !asm_full;
  assign asm_waddr = asm_cnt[AW-1:0];
  assign asm_wdata = item.data;
  assign asm_raddr = cj[AW-1:0];

  // copy pipeline: the slot is written in the cycle after the buffer read
  assign slot_we    = (state == S_COPY) && wv;
  assign slot_waddr = MW'(base + MW'(wj));
  assign slot_wdata = asm_rdata;
  assign slot_raddr = (state == S_CHECK) ? MW'(base + MW'(1)) : MW'(base + MW'(ej));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      store_index <= '0;
      read_index  <= SW'(MAX_SLOTS - 1);
      filled      <= '0;
      outstanding <= '0;
      peak        <= '0;
      period_cnt  <= '0;
      asm_cnt     <= '0;
      asm_ovf     <= 1'b0;
      queued      <= '0;
      out_valid   <= 1'b0;
      wv          <= 1'b0;
      for (int k = 0; k < MAX_SLOTS; k++) begin
        slot_len[k] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.operation == OP_STORE) begin
              if (item.last) begin
                asm_cnt <= '0;
                asm_ovf <= 1'b0;
                if (asm_ovf || asm_full) begin
                  pend_status <= ST_STORE_LEN;
                  pend_len    <= '0;
                  state       <= S_RES;
                end else begin
                  len                   <= asm_len;
                  slot_len[store_index] <= asm_len;
                  queued[store_index]   <= 1'b1;
                  base        <= MW'(int'(store_index) * MAX_BYTES);
                  cj          <= '0;
                  wv          <= 1'b0;
                  store_index <= wrap(store_index, n);
                  if (32'(filled) < 32'(n)) begin
                    filled <= filled + 1'b1;
                  end
                  outstanding <= out_inc;
                  // peak restarts at the end of each statistics period
                  if (period_inc >= cfg.period) begin
                    peak       <= out_inc;
                    period_cnt <= '0;
                  end else begin
                    period_cnt <= period_inc;
                    if (peak < out_inc) begin
                      peak <= out_inc;
                    end
                  end
                  pend_status <= ST_OK;
                  pend_len    <= asm_len;
                  state       <= S_COPY;
                end
              end else if (!asm_full) begin
                asm_cnt <= asm_len;
              end else begin
                asm_ovf <= 1'b1;
              end
            end else begin
              cand      <= wrap(read_index, n);
              remaining <= n;
              limit     <= item.limit;
              state     <= S_SCAN;
            end
          end
        end
        S_COPY: begin
          if (cj != len) begin
            cj <= LW'(cj + 1'b1);
            wj <= cj;
            wv <= 1'b1;
          end else begin
            wv <= 1'b0;
            if (!wv) begin
              state <= S_RES;
            end
          end
        end
        S_RES: begin
          if (out_free) begin
            res <= '{data: '0, last: 1'b1, status: pend_status, len: LEN_W'(pend_len),
                     fill: filled, peak: peak};
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (queued[cand]) begin
            read_index   <= cand;
            queued[cand] <= 1'b0;
            if (outstanding != '0) begin
              outstanding <= outstanding - 1'b1;
            end
            len  <= slot_len[cand];
            base <= MW'(int'(cand) * MAX_BYTES);
            if (LIMIT_W'(slot_len[cand]) > limit) begin
              pend_status <= ST_TOO_LONG;
              pend_len    <= '0;
              state       <= S_RES;
            end else if (slot_len[cand] < LW'(2)) begin
              // no second byte to check against the length
              pend_status <= ST_MISMATCH;
              pend_len    <= '0;
              state       <= S_RES;
            end else begin
              state <= S_CHECK;
            end
          end else if (remaining == NW'(1)) begin
            pend_status <= ST_NONE;
            pend_len    <= '0;
            state       <= S_RES;
          end else begin
            cand      <= wrap(cand, n);
            remaining <= remaining - 1'b1;
          end
        end
        S_CHECK: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (slot_rdata != BYTE_W'(len)) begin
            pend_status <= ST_MISMATCH;
            pend_len    <= '0;
            state       <= S_RES;
          end else begin
            ej    <= '0;
            state <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            res <= '{data: slot_rdata, last: emit_last, status: ST_OK, len: LEN_W'(len),
                     fill: filled, peak: peak};
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              ej    <= LW'(ej + 1'b1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/packet_ring_queue_checked.sv */
// packet ring queue: top level with configuration registers, sequencer and memories
//
// Input requests carry operation, data_byte, last_byte and reader_limit and are
// taken when in_valid is high and in_stall low. A store request that is not the
// last byte of a packet gives no result and leaves in_stall low. A last byte
// starts a copy of the assembled packet into its ring slot, one byte a cycle,
// then one result. A read request scans the ring one slot a cycle from the slot
// after the last one read (up to slots_in_use slots), checks the second byte
// against the length, then delivers the packet bytes one at a time, each read
// through the registered read port of the slot memory. Errors give a single
// result. in_stall stays high until the last result of a request is loaded
// into the output register, so a new request can be taken while that result waits.
// Results are held in the output register while out_stall is high.
// The configuration channel (index 0 slots_in_use, 1 statistic_period) is always
// ready; the user must write it only while the block is idle, which the block
// itself does not enforce. Synchronous reset empties the ring and statistics and
// restores the register defaults; the slot and assembly memories need no clearing.
module packet_ring_queue_checked #(
  parameter int MAX_SLOTS = prq_pkg::MAX_SLOTS_DEF,
  parameter int MAX_BYTES = prq_pkg::MAX_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [prq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [prq_pkg::STAT_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            operation,
  input  logic [prq_pkg::BYTE_W-1:0]      data_byte,
  input  logic                            last_byte,
  input  logic [prq_pkg::LIMIT_W-1:0]     reader_limit,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [prq_pkg::BYTE_W-1:0]      out_byte,
  output logic                            out_last,
  output logic [prq_pkg::STATUS_W-1:0]    status,
  output logic [prq_pkg::LEN_W-1:0]       packet_length,
  output logic [prq_pkg::FILL_W-1:0]      fill_count,
  output logic [prq_pkg::STAT_W-1:0]      peak_stored
);
  import prq_pkg::*;

  localparam int AW = $clog2(MAX_BYTES);
  localparam int MW = $clog2(MAX_SLOTS * MAX_BYTES);

  cfg_t  cfg;
  item_t item;
  res_t  res;

  logic              asm_we;
  logic [AW-1:0]     asm_waddr;
  logic [AW-1:0]     asm_raddr;
  logic [BYTE_W-1:0] asm_wdata;
  logic [BYTE_W-1:0] asm_rdata;
  logic              slot_we;
  logic [MW-1:0]     slot_waddr;
  logic [MW-1:0]     slot_raddr;
  logic [BYTE_W-1:0] slot_wdata;
  logic [BYTE_W-1:0] slot_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slots  <= SLOTS_RST;
      cfg.period <= PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLOTS:  cfg.slots  <= cfg_data[SLOTS_W-1:0];
        CFG_PERIOD: cfg.period <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign item = '{operation: operation, data: data_byte, last: last_byte, limit: reader_limit};

  prq_ctrl #(
    .MAX_SLOTS (MAX_SLOTS),
    .MAX_BYTES (MAX_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .item       (item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res        (res),
    .asm_we     (asm_we),
    .asm_waddr  (asm_waddr),
    .asm_wdata  (asm_wdata),
    .asm_raddr  (asm_raddr),
    .asm_rdata  (asm_rdata),
    .slot_we    (slot_we),
    .slot_waddr (slot_waddr),
    .slot_wdata (slot_wdata),
    .slot_raddr (slot_raddr),
    .slot_rdata (slot_rdata)
  );

  prq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_BYTES)
  ) u_asm_ram (
    .clk   (clk),
    .we    (asm_we),
    .waddr (asm_waddr),
    .wdata (asm_wdata),
    .raddr (asm_raddr),
    .rdata (asm_rdata)
  );

  prq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_SLOTS * MAX_BYTES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  assign out_byte      = res.data;
  assign out_last      = res.last;
  assign status        = res.status;
  assign packet_length = res.len;
  assign fill_count    = res.fill;
  assign peak_stored   = res.peak;

endmodule

/* src/prq_checker.sv */
// port-level checks of the packet ring queue, bound to the top level
module prq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            operation,
  input logic                            last_byte,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [prq_pkg::BYTE_W-1:0]      out_byte,
  input logic                            out_last,
  input logic [prq_pkg::STATUS_W-1:0]    status,
  input logic [prq_pkg::LEN_W-1:0]       packet_length
);
  import prq_pkg::*;

  // a request that yields results holds off the next one
  a_busy_after_result_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (operation == OP_READ || last_byte) |=> in_stall)
    else $error("request with results did not stall the input");

  // a byte that only joins the assembly leaves the block ready
  a_ready_after_plain_store: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && operation == OP_STORE && !last_byte |=> !in_stall)
    else $error("plain store byte stalled the input");

  a_error_is_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> out_last && packet_length == '0 && out_byte == '0)
    else $error("error result not a single zero-length result");

  a_mid_packet_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> status == ST_OK && packet_length != '0)
    else $error("packet byte without ok status or length");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind packet_ring_queue_checked prq_checker u_prq_checker (.*);
